// File: sv/ntc_pkg.sv
// Shared types and constants for the thermistor ADC to temperature converter.
// Used by the top level and its port checker; no dependencies of its own.
package ntc_pkg;

   // Default geometry of the calibration table
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int SAMPLE_BITS_DEF = 12;

   // Fixed field widths of the transactions and registers
   localparam int FUNC_W       = 1;
   localparam int ENTRY_IDX_W  = 8;
   localparam int ENTRY_VAL_W  = 12;
   localparam int SAMPLE_W     = 12;
   localparam int TEMP_W       = 13;
   localparam int SEG_W        = 9;
   localparam int ENTRIES_W    = 9;
   localparam int CLAMP_IDX_W  = 9;
   localparam int TEMP_REF_W   = 8;
   localparam int CSR_DATA_W   = 9;
   localparam int CSR_INDEX_W  = 2;

   // Register reset values
   localparam logic [ENTRIES_W-1:0]          ENTRIES_RST   = 9'd256;
   localparam logic [CLAMP_IDX_W-1:0]        CLAMP_LO_RST  = 9'd1;
   localparam logic [CLAMP_IDX_W-1:0]        CLAMP_HI_RST  = 9'd255;
   localparam logic signed [TEMP_REF_W-1:0]  TEMP_REF_RST  = -8'sd40;

   // Output temperature saturation bounds, tenths of a degree
   localparam int TEMP_LO = -4096;
   localparam int TEMP_HI = 4095;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD    = 1'b0,
      FUNC_CONVERT = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENTRIES_IN_USE = 2'd0,
      CSR_CLAMP_LO       = 2'd1,
      CSR_CLAMP_HI       = 2'd2,
      CSR_TEMP_REF       = 2'd3
   } csr_index_type;

   typedef struct packed {
      func_type                 func;
      logic [ENTRY_IDX_W-1:0]   entry_index;
      logic [ENTRY_VAL_W-1:0]   entry_value;
      logic [SAMPLE_W-1:0]      sample;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_tenths;
      logic [SEG_W-1:0]         segment_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_SELECT,
      ST_READ_A,
      ST_READ_B,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// File: sv/ntc_adc_to_temperature.sv
// Thermistor ADC sample to temperature converter: calibration table, binary search,
// interpolation. Depends on ntc_pkg and ntc_div.
//
// A load transaction writes one calibration entry. A convert transaction is taken only
// while the sequencer is idle; it runs a binary search through the single table read
// port (an entry count below two skips the search and its probe issue state), then
// clamp selection and result load. A sample that lands on a clamp index returns after
// that; one that needs interpolation also reads its segment ends and runs the serial
// divider, which a flat segment skips. A finished result sits in the output register,
// so the next transaction is accepted while it waits to be taken.
// The table is not cleared by reset; convert only after the entries it searches
// have been loaded.
module ntc_adc_to_temperature #(
   parameter int TABLE_DEPTH = ntc_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = ntc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ntc_pkg::req_type                req,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ntc_pkg::rsp_type                rsp,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  ntc_pkg::csr_index_type          csr_index,
   input  logic [ntc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ntc_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = ($clog2(TABLE_DEPTH + 1) > ENTRIES_W) ?
                           $clog2(TABLE_DEPTH + 1) : ENTRIES_W;
   localparam int BASE_W = CNT_W + 2;
   localparam int B10_W  = BASE_W + 4;
   localparam int MAG_W  = SAMPLE_BITS + 4;
   localparam int NUM_W  = MAG_W + 1;
   localparam int SUM_W  = ((B10_W > NUM_W) ? B10_W : NUM_W) + 1;

   // Configuration registers
   logic [ENTRIES_W-1:0]          entries_ff;
   logic [CLAMP_IDX_W-1:0]        clamp_lo_ff;
   logic [CLAMP_IDX_W-1:0]        clamp_hi_ff;
   logic signed [TEMP_REF_W-1:0]  temp_ref_ff;

   // Sequencer and datapath
   state_type                state_ff, state_in;
   logic [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]   a_ff, a_in;
   logic signed [SUM_W-1:0]  base10_ff, base10_in;
   logic                     neg_ff, neg_in;
   logic [TEMP_W-1:0]        temp_ff, temp_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Calibration table
   logic [SAMPLE_BITS-1:0]   adc_table_ff [TABLE_DEPTH];
   logic [SAMPLE_BITS-1:0]   rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;

   logic                     req_take;
   logic [CNT_W-1:0]         n_eff;
   logic [CNT_W:0]           sum_cur, sum_nxt;
   logic [CNT_W-1:0]         mid_cur, mid_nxt;
   logic [CNT_W-1:0]         sel_idx;
   logic                     clamp;
   logic signed [BASE_W-1:0] base;
   logic signed [SUM_W-1:0]  base_x, base10;
   logic [SAMPLE_BITS-1:0]   b_val;
   logic signed [SAMPLE_BITS:0] diff_n, diff_d;
   logic signed [NUM_W-1:0]  num_x, num;
   logic [MAG_W-1:0]         num_mag;
   logic [SAMPLE_BITS-1:0]   den_mag;
   logic                     div_start, div_done;
   logic [MAG_W-1:0]         q_mag;
   logic signed [SUM_W-1:0]  q_x, q_s;

   function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [SUM_W-1:0] v);
      if (v < SUM_W'(TEMP_LO)) return TEMP_W'(TEMP_LO);
      if (v > SUM_W'(TEMP_HI)) return TEMP_W'(TEMP_HI);
      return v[TEMP_W-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign mem_we    = req_take && (req.func == FUNC_LOAD) &&
                      (int'(req.entry_index) < TABLE_DEPTH);

   assign n_eff = (CNT_W'(entries_ff) > CNT_W'(TABLE_DEPTH)) ?
                  CNT_W'(TABLE_DEPTH) : CNT_W'(entries_ff);

   assign sum_cur = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cur = sum_cur[CNT_W:1];
   assign sum_nxt = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_nxt = sum_nxt[CNT_W:1];

   // Clamp selection and segment base temperature, 10 * (index + temp_ref - 1)
   always_comb begin
      clamp   = 1'b1;
      sel_idx = lo_ff;
      if (lo_ff >= CNT_W'(clamp_hi_ff)) begin
         sel_idx = CNT_W'(clamp_hi_ff);
      end else if (lo_ff <= CNT_W'(clamp_lo_ff)) begin
         sel_idx = CNT_W'(clamp_lo_ff);
      end else begin
         clamp = 1'b0;
      end
      base   = BASE_W'({2'b00, sel_idx}) + BASE_W'(temp_ref_ff) - BASE_W'(1);
      base_x = SUM_W'(base);
      base10 = (base_x <<< 3) + (base_x <<< 1);
   end

   // Interpolation operands: 10 * (a - s) over (a - b)
   always_comb begin
      b_val   = (lo_ff < CNT_W'(TABLE_DEPTH)) ? rd_data_ff : '0;
      diff_n  = $signed({1'b0, a_ff}) - $signed({1'b0, sample_ff});
      diff_d  = $signed({1'b0, a_ff}) - $signed({1'b0, b_val});
      num_x   = NUM_W'(diff_n);
      num     = (num_x <<< 3) + (num_x <<< 1);
      num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      den_mag = diff_d[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_d) : SAMPLE_BITS'(diff_d);
      q_x     = SUM_W'({1'b0, q_mag});
      q_s     = neg_ff ? -q_x : q_x;
   end

   ntc_div #(
      .QW(MAG_W),
      .DW(SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (q_mag)
   );

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      base10_in    = base10_ff;
      neg_in       = neg_ff;
      temp_in      = temp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = mid_cur[IDX_W-1:0];
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req.func == FUNC_CONVERT)) begin
               sample_in = SAMPLE_BITS'(req.sample);
               lo_in     = CNT_W'(1);
               hi_in     = n_eff - CNT_W'(1);
               // fewer than two entries: nothing to search
               state_in  = (n_eff < CNT_W'(2)) ? ST_SELECT : ST_PROBE;
            end
         end
         ST_PROBE: begin
            rd_addr  = mid_cur[IDX_W-1:0];
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (sample_ff > rd_data_ff) begin
               lo_in = mid_cur + CNT_W'(1);
            end else begin
               hi_in = mid_cur - CNT_W'(1);
            end
            // issue the next probe straight from the updated bounds
            rd_addr = mid_nxt[IDX_W-1:0];
            if (lo_in > hi_in) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            base10_in = base10;
            rd_addr   = IDX_W'(lo_ff - CNT_W'(1));
            if (clamp) begin
               temp_in  = sat_temp(base10);
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ_A;
            end
         end
         ST_READ_A: begin
            a_in     = rd_data_ff;
            rd_addr  = lo_ff[IDX_W-1:0];
            state_in = ST_READ_B;
         end
         ST_READ_B: begin
            neg_in = num[NUM_W-1] ^ diff_d[SAMPLE_BITS];
            if (den_mag == '0) begin
               // flat segment: the quotient is zero
               temp_in  = sat_temp(base10_ff);
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               temp_in  = sat_temp(q_s + base10_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.temperature_tenths = $signed(temp_ff);
               rsp_in.segment_index      = lo_ff[SEG_W-1:0];
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= ENTRIES_RST;
         clamp_lo_ff  <= CLAMP_LO_RST;
         clamp_hi_ff  <= CLAMP_HI_RST;
         temp_ref_ff  <= TEMP_REF_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ENTRIES_IN_USE: entries_ff   <= csr_data[ENTRIES_W-1:0];
               CSR_CLAMP_LO:       clamp_lo_ff  <= csr_data[CLAMP_IDX_W-1:0];
               CSR_CLAMP_HI:       clamp_hi_ff  <= csr_data[CLAMP_IDX_W-1:0];
               CSR_TEMP_REF:       temp_ref_ff  <= $signed(csr_data[TEMP_REF_W-1:0]);
            endcase
         end
      end
      sample_ff <= sample_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      a_ff      <= a_in;
      base10_ff <= base10_in;
      neg_ff    <= neg_in;
      temp_ff   <= temp_in;
      rsp_ff    <= rsp_in;
   end

   // Table memory: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adc_table_ff[IDX_W'(req.entry_index)] <= SAMPLE_BITS'(req.entry_value);
      end
      rd_data_ff <= adc_table_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/ntc_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Stand-alone; started by the converter's sequencer.
module ntc_div #(
   parameter int QW = 16,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = (QW > 1) ? $clog2(QW) : 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW:0]   rem_sh;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[QW-1]};
      ge      = (rem_sh >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         quo_in = {quo_ff[QW-2:0], ge};
         rem_in = ge ? DW'(rem_sh - {1'b0, div_ff}) : rem_sh[DW-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/ntc_chk.sv
// Port-level checker for the thermistor converter, bound to the top level.
// Depends on ntc_pkg for the transaction types.
module ntc_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ntc_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ntc_pkg::rsp_type rsp
);
   import ntc_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp))
      else $error("stalled result payload changed");

   // no transaction produces a result in the very next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after a transaction");

   // a convert occupies the sequencer
   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.func == FUNC_CONVERT) |=> req_stall)
      else $error("input not stalled after a convert transaction");

endmodule

bind ntc_adc_to_temperature ntc_chk u_ntc_chk (.*);

// File: tb/tb_top.sv
// Self-checking testbench for ntc_adc_to_temperature: table loads, conversions, CSR writes.
// Depends on ntc_pkg and the ntc_adc_to_temperature RTL; predicts each temperature itself.
`timescale 1ns / 100ps

module tb_top;
   import ntc_pkg::*;

   localparam int CLOCK_PERIOD      = 20;
   localparam int RESET_CYCLES      = 9;
   localparam int TENTHS_PER_DEGREE = 10;
   localparam int SETTLE_CYCLES     = 40;
   localparam int HOLD_CYCLES       = 300;
   localparam int CYCLE_LIMIT       = 600000;
   localparam int ROUNDS            = 8;
   localparam int ROUND_ITEMS       = 180;
   localparam int MAX_PRINTED       = 100;
   localparam int ADC_MAX           = (1 << SAMPLE_W) - 1;

   class ntc_checker;
      logic [ENTRY_VAL_W-1:0] table_copy [TABLE_DEPTH_DEF];
      longint entries_in_use;
      longint clamp_lo;
      longint clamp_hi;
      longint temp_ref;
      rsp_type temps_due [$];
      int failures;

      function new();
         foreach (table_copy[i]) table_copy[i] = '0;
         entries_in_use = longint'(ENTRIES_RST);
         clamp_lo       = longint'(CLAMP_LO_RST);
         clamp_hi       = longint'(CLAMP_HI_RST);
         temp_ref       = longint'(TEMP_REF_RST);
         failures       = 0;
      endfunction

      task report_mismatch(string what);
         if (failures < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
         failures++;
      endtask

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENTRIES_IN_USE: entries_in_use = longint'(data);
            CSR_CLAMP_LO:       clamp_lo = longint'(data);
            CSR_CLAMP_HI:       clamp_hi = longint'(data);
            CSR_TEMP_REF:       temp_ref = longint'($signed(data[TEMP_REF_W-1:0]));
            default: ;
         endcase
      endfunction

      // Entries past the end of the table read as zero
      function longint table_entry(longint i);
         return (i < 0 || i >= TABLE_DEPTH_DEF) ? 0 : longint'(table_copy[i]);
      endfunction

      function rsp_type convert_sample(logic [SAMPLE_W-1:0] s);
         longint sv, n, lo, hi, mid, seg, a, b, t;
         rsp_type out;
         sv = longint'(s);
         n = (entries_in_use > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : entries_in_use;
         lo = 1;
         hi = n - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (sv > table_entry(mid)) lo = mid + 1;
            else hi = mid - 1;
         end
         seg = lo;
         if (seg >= clamp_hi) begin
            t = TENTHS_PER_DEGREE * (clamp_hi + temp_ref - 1);
         end else if (seg <= clamp_lo) begin
            t = TENTHS_PER_DEGREE * (clamp_lo + temp_ref - 1);
         end else begin
            a = table_entry(seg - 1);
            b = table_entry(seg);
            // flat segment: no slope, stay at the segment base
            t = (a == b) ? 0 : (TENTHS_PER_DEGREE * (a - sv)) / (a - b);
            t += TENTHS_PER_DEGREE * (seg + temp_ref - 1);
         end
         if (t < TEMP_LO) t = TEMP_LO;
         else if (t > TEMP_HI) t = TEMP_HI;
         out.temperature_tenths = t[TEMP_W-1:0];
         out.segment_index      = seg[SEG_W-1:0];
         return out;
      endfunction

      function void note_request(req_type item);
         if (item.func == FUNC_LOAD) table_copy[item.entry_index] = item.entry_value;
         else temps_due.push_back(convert_sample(item.sample));
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (temps_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: temp %0d seg %0d",
                                      got.temperature_tenths, got.segment_index));
            return;
         end
         want = temps_due.pop_front();
         if (got.temperature_tenths !== want.temperature_tenths)
            report_mismatch($sformatf("temperature_tenths %0d, predicted %0d",
                                      got.temperature_tenths, want.temperature_tenths));
         if (got.segment_index !== want.segment_index)
            report_mismatch($sformatf("segment_index %0d, predicted %0d",
                                      got.segment_index, want.segment_index));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_ENTRIES_IN_USE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   ntc_checker sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int cycle_count = 0;

   ntc_adc_to_temperature dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp);
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_requests > holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic req_type load_item(int idx, int value);
      req_type item;
      item.func        = FUNC_LOAD;
      item.entry_index = idx[ENTRY_IDX_W-1:0];
      item.entry_value = value[ENTRY_VAL_W-1:0];
      item.sample      = SAMPLE_W'($urandom);
      return item;
   endfunction

   function automatic req_type convert_item(int value);
      req_type item;
      item.func        = FUNC_CONVERT;
      item.entry_index = ENTRY_IDX_W'($urandom);
      item.entry_value = ENTRY_VAL_W'($urandom);
      item.sample      = value[SAMPLE_W-1:0];
      return item;
   endfunction

   // Call at a rising edge; returns at the edge that takes the transaction
   task automatic send_request(input req_type item);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value);
   endtask

   task automatic apply_settings(input int entries, input int imin, input int imax,
                                 input int tref);
      write_register(CSR_ENTRIES_IN_USE, entries[CSR_DATA_W-1:0]);
      write_register(CSR_CLAMP_LO, imin[CSR_DATA_W-1:0]);
      write_register(CSR_CLAMP_HI, imax[CSR_DATA_W-1:0]);
      write_register(CSR_TEMP_REF, tref[CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, drain pending conversions, then give a trailing load time to land
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.temps_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_round(input bit noisy, input int count, input int hold_at);
      int i, e, lo, hi, v, pick;
      for (i = 0; i < count; i++) begin
         if (i == hold_at) hold_requests++;
         if ($urandom_range(99) < (noisy ? 30 : 10)) begin
            // keep the table ascending where there is room, unless this round scrambles it
            e  = $urandom_range(TABLE_DEPTH_DEF - 1);
            lo = (e == 0) ? 0 : int'(sb.table_copy[e-1]) + 1;
            hi = (e == TABLE_DEPTH_DEF - 1) ? ADC_MAX : int'(sb.table_copy[e+1]) - 1;
            if (!noisy && lo <= hi) v = $urandom_range(hi, lo);
            else v = $urandom_range(ADC_MAX);
            send_request(load_item(e, v));
         end else begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               v = int'(sb.table_copy[$urandom_range(TABLE_DEPTH_DEF - 1)]) +
                   int'($urandom_range(2)) - 1;
               if (v < 0) v = 0;
               if (v > ADC_MAX) v = ADC_MAX;
            end else if (pick < 90) begin
               v = $urandom_range(ADC_MAX);
            end else begin
               v = $urandom_range(1) ? ADC_MAX : 0;
            end
            send_request(convert_item(v));
         end
      end
   endtask

   initial begin : wdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ntc_adc_to_temperature: mismatch");
      $finish;
   end

   initial begin : stimulus
      int round_entries [ROUNDS];
      int round_min [ROUNDS];
      int round_max [ROUNDS];
      int round_ref [ROUNDS];
      int i, r, e1, mode;
      round_entries = '{256, 256, 2, 17, 300, 1, 200, 0};
      round_min     = '{1, 0, 0, 5, 1, 0, 30, 0};
      round_max     = '{255, 256, 2, 12, 300, 511, 150, 0};
      round_ref     = '{-40, 127, -128, 25, -1, 0, 100, 0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table ascending, from 0 at entry zero up to the ADC maximum
      for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
         if (i == 0) send_request(load_item(0, 0));
         else if (i == TABLE_DEPTH_DEF - 1) send_request(load_item(i, ADC_MAX));
         else send_request(load_item(i, i * 16 + $urandom_range(15)));
      end

      // Directed conversions at the reset settings
      send_request(convert_item(0));
      send_request(convert_item(ADC_MAX));
      send_request(convert_item(int'(sb.table_copy[128])));
      send_request(convert_item(int'(sb.table_copy[128]) + 1));
      send_request(convert_item(int'(sb.table_copy[1]) + 1));
      send_request(convert_item(int'(sb.table_copy[254])));
      send_request(load_item(TABLE_DEPTH_DEF - 1, ADC_MAX - 1));
      send_request(convert_item(ADC_MAX));

      // Oversized entry count, low clamp off, high clamp out of reach
      settle();
      apply_settings(511, 0, 511, 127);
      e1 = int'(sb.table_copy[1]);
      send_request(load_item(0, e1));
      send_request(convert_item(e1));
      send_request(convert_item(ADC_MAX));
      send_request(load_item(0, ADC_MAX - 1));
      send_request(load_item(1, ADC_MAX));
      send_request(convert_item(0));
      send_request(load_item(0, ADC_MAX));
      send_request(load_item(1, ADC_MAX - 1));
      send_request(convert_item(0));
      send_request(load_item(1, e1));
      send_request(load_item(0, 0));

      // Degenerate entry counts with both clamps
      settle();
      apply_settings(0, 511, 511, 127);
      send_request(convert_item($urandom_range(ADC_MAX)));
      settle();
      apply_settings(1, 511, 0, -128);
      send_request(convert_item($urandom_range(ADC_MAX)));

      for (r = 0; r < ROUNDS; r++) begin
         settle();
         if (r == ROUNDS - 1)
            apply_settings($urandom_range(511), $urandom_range(511), $urandom_range(511),
                           $urandom_range(511));
         else
            apply_settings(round_entries[r], round_min[r], round_max[r], round_ref[r]);
         mode = r % 4;
         send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 16 : 0;
         stall_pct     = (mode == 2) ? 53 : (mode == 3) ? 16 : 0;
         run_round(r == 6, ROUND_ITEMS, (mode == 0) ? 40 : -1);
      end

      req_valid <= 1'b0;
      while (sb.temps_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("ntc_adc_to_temperature: match");
      else
         $display("ntc_adc_to_temperature: mismatch");
      $finish;
   end

endmodule
